/* hdl/arq_rst_pkg.sv */
// shared types, sizes and codes for the arq retransmit slot tracker
// no dependencies; used by the slot stores and the top level
`default_nettype none

package arq_rst_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    // wide enough to compare a 4-bit slot field against SLOTS
    localparam int SCMP_W  = (SLOT_W + 1 > 5) ? SLOT_W + 1 : 5;
    localparam int MAX_OUT = 16;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    localparam logic [2:0] CMD_SEND = 3'd0;
    localparam logic [2:0] CMD_ACK  = 3'd1;
    localparam logic [2:0] CMD_TICK = 3'd2;
    localparam logic [2:0] CMD_DATA = 3'd3;
    localparam logic [2:0] CMD_READ = 3'd4;

    localparam logic [2:0] KIND_TX        = 3'd0;
    localparam logic [2:0] KIND_RETX      = 3'd1;
    localparam logic [2:0] KIND_SEND_ACK  = 3'd2;
    localparam logic [2:0] KIND_DELIVERED = 3'd3;
    localparam logic [2:0] KIND_NO_DATA   = 3'd4;
    localparam logic [2:0] KIND_ACK_ABS   = 3'd5;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_HEADER  = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  slot;
        logic [15:0] length;
        logic [7:0]  peer;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  out_slot;
        logic [15:0] out_length;
        logic [7:0]  out_peer;
        logic [31:0] transmissions;
        logic        any_pending;
        logic        last;
    } res_item_t;

    typedef struct packed {
        logic [15:0] stamp;
        logic [15:0] size;
        logic [7:0]  dest;
    } tx_entry_t;

    typedef struct packed {
        logic [15:0] size;
        logic [15:0] consumed;
        logic [7:0]  source;
    } rx_entry_t;

endpackage

`default_nettype wire

/* hdl/arq_retransmit_slot_tracker_unit.sv */
// send, ack and data items give their result in the cycle after acceptance; a zero-length send or a
// refused data item gives none. a tick sweeps every slot through one elapsed-time comparator (a read,
// then a compare per slot), then scans the due mask up to the last due one, loading each retransmit
// and then holding its result. a host read scans the full bits up to the first full slot, then updates it in
// a take and a finish step. one item at a time: the next is taken in the cycle after the last result
// is taken. reset clears control state and counters; slot memories stay unset, no clear pass
`default_nettype none

module arq_retransmit_slot_tracker_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire arq_rst_pkg::cmd_item_t cmd,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output arq_rst_pkg::res_item_t      res,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [15:0]            cfg_data
);

    localparam int SLOTS  = arq_rst_pkg::SLOTS;
    localparam int SLOT_W = arq_rst_pkg::SLOT_W;
    localparam int CNT_W  = arq_rst_pkg::CNT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_T_RD   = 4'd1;
    localparam logic [3:0] S_T_CMP  = 4'd2;
    localparam logic [3:0] S_E_SCAN = 4'd3;
    localparam logic [3:0] S_E_LOAD = 4'd4;
    localparam logic [3:0] S_R_SCAN = 4'd5;
    localparam logic [3:0] S_R_TAKE = 4'd6;
    localparam logic [3:0] S_R_FIN  = 4'd7;
    localparam logic [3:0] S_WAIT   = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] next_slot_reg, next_slot_next;
    logic [SLOTS-1:0]  pend_reg, pend_next;
    logic [SLOTS-1:0]  full_reg, full_next;
    logic [SLOTS-1:0]  due_reg, due_next;
    logic [CNT_W-1:0]  due_cnt_reg, due_cnt_next;
    logic [31:0]       total_reg, total_next;
    logic [15:0]       now_reg, now_next;
    logic [15:0]       timeout_reg;
    logic [7:0]        header_reg;
    logic              res_valid_reg, res_valid_next;

    arq_rst_pkg::cmd_item_t item_reg, item_next;
    arq_rst_pkg::res_item_t res_reg, res_next;
    logic [15:0]            take_reg, take_next;

    logic                   tx_we, tx_stamp_only;
    logic [SLOT_W-1:0]      tx_waddr;
    arq_rst_pkg::tx_entry_t tx_wdata, tx_rdata;
    logic                   rx_we, rx_consumed_only;
    logic [SLOT_W-1:0]      rx_waddr;
    arq_rst_pkg::rx_entry_t rx_wdata, rx_rdata;

    logic [SLOT_W-1:0] in_idx;
    logic              slot_ok;
    logic [16:0]       size_sum;
    logic [15:0]       size_sat;
    logic [SLOTS-1:0]  sel;
    logic [SLOTS-1:0]  in_sel;
    logic [SLOTS-1:0]  ns_sel;
    logic [15:0]       elapsed;
    logic              hit;
    logic [16:0]       cons_sum;
    logic [15:0]       cons_sat;
    logic [15:0]       give;
    logic              idx_last;

    arq_rst_tx_store u_tx_store (
        .clk        (clk),
        .we         (tx_we),
        .stamp_only (tx_stamp_only),
        .waddr      (tx_waddr),
        .wdata      (tx_wdata),
        .raddr      (idx_reg),
        .rdata      (tx_rdata)
    );

    arq_rst_rx_store u_rx_store (
        .clk           (clk),
        .we            (rx_we),
        .consumed_only (rx_consumed_only),
        .waddr         (rx_waddr),
        .wdata         (rx_wdata),
        .raddr         (idx_reg),
        .rdata         (rx_rdata)
    );

    assign in_idx   = SLOT_W'(cmd.slot);
    assign slot_ok  = arq_rst_pkg::SCMP_W'(cmd.slot) < arq_rst_pkg::SCMP_W'(SLOTS);
    assign size_sum = 17'(cmd.length) + 17'(header_reg);
    assign size_sat = size_sum[16] ? 16'hFFFF : size_sum[15:0];
    assign sel      = SLOTS'(1) << idx_reg;
    assign in_sel   = SLOTS'(1) << in_idx;
    assign ns_sel   = SLOTS'(1) << next_slot_reg;
    assign idx_last = idx_reg == SLOT_W'(SLOTS - 1);

    // the shared comparator: elapsed ticks modulo 2^16 against the timeout
    assign elapsed = now_reg - tx_rdata.stamp;
    assign hit     = ((pend_reg & sel) != '0) && (elapsed > timeout_reg)
                     && (due_cnt_reg < CNT_W'(arq_rst_pkg::MAX_OUT));

    assign cons_sum = 17'(rx_rdata.consumed) + 17'(take_reg);
    assign cons_sat = cons_sum[16] ? 16'hFFFF : cons_sum[15:0];
    assign give     = (take_reg > 16'(header_reg)) ? take_reg - 16'(header_reg) : 16'd0;

    assign tx_wdata.stamp = now_reg;
    assign tx_wdata.size  = size_sat;
    assign tx_wdata.dest  = cmd.peer;

    assign rx_wdata.size     = cmd.length;
    assign rx_wdata.consumed = (state_reg == S_R_FIN) ? cons_sat : 16'd0;
    assign rx_wdata.source   = cmd.peer;

    always_comb
    begin
        logic [SLOTS-1:0] pend_ack;
        logic [SLOTS-1:0] due_hit;

        state_next     = state_reg;
        idx_next       = idx_reg;
        next_slot_next = next_slot_reg;
        pend_next      = pend_reg;
        full_next      = full_reg;
        due_next       = due_reg;
        due_cnt_next   = due_cnt_reg;
        total_next     = total_reg;
        now_next       = now_reg;
        res_valid_next = res_valid_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        take_next      = take_reg;

        tx_we            = 1'b0;
        tx_stamp_only    = 1'b0;
        tx_waddr         = next_slot_reg;
        rx_we            = 1'b0;
        rx_consumed_only = 1'b0;
        rx_waddr         = in_idx;

        pend_ack = slot_ok ? (pend_reg & ~in_sel) : pend_reg;
        due_hit  = hit ? (due_reg | sel) : due_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next = cmd;
                    res_next.transmissions = total_reg;
                    res_next.any_pending   = |pend_reg;
                    res_next.last          = 1'b1;
                    unique case (cmd.command)
                        arq_rst_pkg::CMD_SEND:
                        begin
                            if (cmd.length != 16'd0)
                            begin
                                tx_we          = 1'b1;
                                pend_next      = pend_reg | ns_sel;
                                next_slot_next = (next_slot_reg == SLOT_W'(SLOTS - 1))
                                                 ? '0 : next_slot_reg + SLOT_W'(1);
                                total_next     = total_reg + 32'd1;
                                res_next.kind          = arq_rst_pkg::KIND_TX;
                                res_next.out_slot      = 4'(next_slot_reg);
                                res_next.out_length    = size_sat;
                                res_next.out_peer      = cmd.peer;
                                res_next.transmissions = total_reg + 32'd1;
                                res_next.any_pending   = 1'b1;
                                res_valid_next = 1'b1;
                                state_next     = S_WAIT;
                            end
                        end
                        arq_rst_pkg::CMD_ACK:
                        begin
                            pend_next = pend_ack;
                            res_next.kind        = arq_rst_pkg::KIND_ACK_ABS;
                            res_next.out_slot    = cmd.slot;
                            res_next.out_length  = 16'd0;
                            res_next.out_peer    = 8'd0;
                            res_next.any_pending = |pend_ack;
                            res_valid_next = 1'b1;
                            state_next     = S_WAIT;
                        end
                        arq_rst_pkg::CMD_TICK:
                        begin
                            now_next     = now_reg + 16'd1;
                            idx_next     = '0;
                            due_next     = '0;
                            due_cnt_next = '0;
                            state_next   = S_T_RD;
                        end
                        arq_rst_pkg::CMD_DATA:
                        begin
                            if (cmd.length >= 16'(header_reg) && slot_ok)
                            begin
                                rx_we     = 1'b1;
                                full_next = full_reg | in_sel;
                                res_next.kind       = arq_rst_pkg::KIND_SEND_ACK;
                                res_next.out_slot   = cmd.slot;
                                res_next.out_length = cmd.length;
                                res_next.out_peer   = cmd.peer;
                                res_valid_next = 1'b1;
                                state_next     = S_WAIT;
                            end
                        end
                        arq_rst_pkg::CMD_READ:
                        begin
                            idx_next   = '0;
                            state_next = S_R_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_T_RD:
            begin
                // read issued at idx, entry arrives next cycle
                state_next = S_T_CMP;
            end
            S_T_CMP:
            begin
                tx_waddr      = idx_reg;
                tx_stamp_only = 1'b1;
                if (hit)
                begin
                    tx_we        = 1'b1;
                    due_next     = due_hit;
                    due_cnt_next = due_cnt_reg + CNT_W'(1);
                    total_next   = total_reg + 32'd1;
                end
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = (due_hit != '0) ? S_E_SCAN : S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + SLOT_W'(1);
                    state_next = S_T_RD;
                end
            end
            S_E_SCAN:
            begin
                if ((due_reg & sel) != '0)
                    state_next = S_E_LOAD;
                else
                    idx_next = idx_reg + SLOT_W'(1);
            end
            S_E_LOAD:
            begin
                due_next = due_reg & ~sel;
                res_next.kind          = arq_rst_pkg::KIND_RETX;
                res_next.out_slot      = 4'(idx_reg);
                res_next.out_length    = tx_rdata.size;
                res_next.out_peer      = tx_rdata.dest;
                res_next.transmissions = total_reg;
                res_next.any_pending   = |pend_reg;
                res_next.last          = (due_reg & ~sel) == '0;
                res_valid_next = 1'b1;
                state_next     = S_WAIT;
            end
            S_R_SCAN:
            begin
                if ((full_reg & sel) != '0)
                begin
                    state_next = S_R_TAKE;
                end
                else if (idx_last)
                begin
                    res_next.kind          = arq_rst_pkg::KIND_NO_DATA;
                    res_next.out_slot      = 4'd0;
                    res_next.out_length    = 16'd0;
                    res_next.out_peer      = 8'd0;
                    res_next.transmissions = total_reg;
                    res_next.any_pending   = |pend_reg;
                    res_next.last          = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_R_TAKE:
            begin
                take_next  = (item_reg.length < rx_rdata.size) ? item_reg.length
                                                               : rx_rdata.size;
                state_next = S_R_FIN;
            end
            S_R_FIN:
            begin
                rx_we            = 1'b1;
                rx_consumed_only = 1'b1;
                rx_waddr         = idx_reg;
                if (cons_sat >= rx_rdata.size)
                    full_next = full_reg & ~sel;
                res_next.kind          = arq_rst_pkg::KIND_DELIVERED;
                res_next.out_slot      = 4'(idx_reg);
                res_next.out_length    = give;
                res_next.out_peer      = rx_rdata.source;
                res_next.transmissions = total_reg;
                res_next.any_pending   = |pend_reg;
                res_next.last          = 1'b1;
                res_valid_next = 1'b1;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                if (res_ready)
                begin
                    res_valid_next = 1'b0;
                    if (res_reg.last)
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // more retransmits remain above this slot
                        idx_next   = idx_reg + SLOT_W'(1);
                        state_next = S_E_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            next_slot_reg <= '0;
            pend_reg      <= '0;
            full_reg      <= '0;
            due_reg       <= '0;
            due_cnt_reg   <= '0;
            total_reg     <= '0;
            now_reg       <= '0;
            timeout_reg   <= 16'd2;
            header_reg    <= 8'd8;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            next_slot_reg <= next_slot_next;
            pend_reg      <= pend_next;
            full_reg      <= full_next;
            due_reg       <= due_next;
            due_cnt_reg   <= due_cnt_next;
            total_reg     <= total_next;
            now_reg       <= now_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == arq_rst_pkg::CFG_TIMEOUT)
                    timeout_reg <= cfg_data;
                else
                    header_reg <= cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        take_reg <= take_next;
    end

    assign cmd_ready = state_reg == S_IDLE;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // no new item while a result is still held
    a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !res_valid)
        else $error("item taken while a result is held");

    // only a tick sweep gives more than one result per item
    a_multi_is_retx: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.last) |-> (res.kind == arq_rst_pkg::KIND_RETX))
        else $error("non-final result that is not a retransmit");

    // a nonzero send shows its transmit result in the next cycle
    a_send_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && cmd.command == arq_rst_pkg::CMD_SEND
         && cmd.length != 16'd0)
        |=> (res_valid && res.kind == arq_rst_pkg::KIND_TX && res.any_pending))
        else $error("send did not give a transmit result");

endmodule

`default_nettype wire

/* hdl/arq_rst_tx_store.sv */
// transmit slot memory: stamp, message size and destination per slot
// depends on arq_rst_pkg; one write port, one registered read port
`default_nettype none

module arq_rst_tx_store (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic                           stamp_only,
    input  wire logic [arq_rst_pkg::SLOT_W-1:0] waddr,
    input  wire arq_rst_pkg::tx_entry_t         wdata,
    input  wire logic [arq_rst_pkg::SLOT_W-1:0] raddr,
    output arq_rst_pkg::tx_entry_t              rdata
);

    logic [15:0] stamp_mem [arq_rst_pkg::SLOTS];
    logic [15:0] size_mem  [arq_rst_pkg::SLOTS];
    logic [7:0]  dest_mem  [arq_rst_pkg::SLOTS];

    arq_rst_pkg::tx_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stamp_mem[waddr] <= wdata.stamp;
            // a retransmit only restamps the slot
            if (!stamp_only)
            begin
                size_mem[waddr] <= wdata.size;
                dest_mem[waddr] <= wdata.dest;
            end
        end
        rdata_reg.stamp <= stamp_mem[raddr];
        rdata_reg.size  <= size_mem[raddr];
        rdata_reg.dest  <= dest_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/arq_rst_rx_store.sv */
// receive slot memory: message size, bytes consumed and source per slot
// depends on arq_rst_pkg; one write port, one registered read port
`default_nettype none

module arq_rst_rx_store (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic                           consumed_only,
    input  wire logic [arq_rst_pkg::SLOT_W-1:0] waddr,
    input  wire arq_rst_pkg::rx_entry_t         wdata,
    input  wire logic [arq_rst_pkg::SLOT_W-1:0] raddr,
    output arq_rst_pkg::rx_entry_t              rdata
);

    logic [15:0] size_mem     [arq_rst_pkg::SLOTS];
    logic [15:0] consumed_mem [arq_rst_pkg::SLOTS];
    logic [7:0]  source_mem   [arq_rst_pkg::SLOTS];

    arq_rst_pkg::rx_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            consumed_mem[waddr] <= wdata.consumed;
            // a host read only updates the consumed count
            if (!consumed_only)
            begin
                size_mem[waddr]   <= wdata.size;
                source_mem[waddr] <= wdata.source;
            end
        end
        rdata_reg.size     <= size_mem[raddr];
        rdata_reg.consumed <= consumed_mem[raddr];
        rdata_reg.source   <= source_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
